@@ rtl/rtce_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtce_pkg
// Shared types, constants and helpers of the RTC field to epoch seconds core.
// ----------------------------------------------------------------------------
package rtce_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned EPOCH_W   = 40;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_IS_BINARY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOURS_24       = 1'd1;

  // pipeline depth, the last stage is the output register
  localparam int unsigned STAGES = 7;

  localparam int unsigned YEAR_W  = 15;   // century * 100 + low year <= 25755
  localparam int unsigned DAYS_W  = 24;   // whole days since the epoch
  localparam int unsigned HMS_W   = 20;   // seconds within the (unchecked) day
  localparam int unsigned MDAYS_W = 9;
  localparam int unsigned MPART_W = 10;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR         = 15'd1970;
  localparam logic [13:0]       LEAPS_BEFORE_EPOCH = 14'd477;
  localparam int unsigned       SECS_PER_DAY       = 86400;
  localparam int unsigned       SECS_PER_HOUR      = 3600;
  localparam int unsigned       SECS_PER_MIN       = 60;
  localparam int unsigned       DAYS_PER_YEAR      = 365;
  localparam int unsigned       PM_HOURS           = 12;

  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x < 2**YEAR_W
  localparam int unsigned DIV100_MUL   = 20972;
  localparam int unsigned DIV100_SHIFT = 21;
  localparam int unsigned PROD_W       = 30;

  typedef struct packed {
    logic data_is_binary;
    logic hours_24;
  } rtce_cfg_t;

  // bcd byte to binary unless bin, invalid nibbles decode arithmetically
  function automatic logic [BYTE_W-1:0] decode(input logic [BYTE_W-1:0] v,
                                               input logic             bin);
    logic [BYTE_W-1:0] hi;
    hi = {4'd0, v[7:4]};
    if (bin) begin
      return v;
    end
    return {4'd0, v[3:0]} + (hi << 3) + (hi << 1);
  endfunction

  // days before the month after the given count of whole months
  function automatic logic [MDAYS_W-1:0] days_before(input logic [3:0] m);
    logic [MDAYS_W-1:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

@@ rtl/rtce_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtce channel interfaces
// Field input, epoch result and configuration write channels.
// ----------------------------------------------------------------------------
interface rtce_fields_if;
  logic                         valid;
  logic                         ready;
  logic [rtce_pkg::BYTE_W-1:0]  raw_seconds;
  logic [rtce_pkg::BYTE_W-1:0]  raw_minutes;
  logic [rtce_pkg::BYTE_W-1:0]  raw_hours;
  logic [rtce_pkg::BYTE_W-1:0]  raw_day;
  logic [rtce_pkg::BYTE_W-1:0]  raw_month;
  logic [rtce_pkg::BYTE_W-1:0]  raw_year_low;
  logic [rtce_pkg::BYTE_W-1:0]  raw_century;

  modport source (output valid, raw_seconds, raw_minutes, raw_hours, raw_day,
                  raw_month, raw_year_low, raw_century, input ready);
  modport sink   (input valid, raw_seconds, raw_minutes, raw_hours, raw_day,
                  raw_month, raw_year_low, raw_century, output ready);
endinterface

interface rtce_result_if;
  logic                         valid;
  logic                         ready;
  logic [rtce_pkg::EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink   (input valid, epoch_seconds, output ready);
endinterface

interface rtce_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rtce_pkg::CFG_IDX_W-1:0] index;
  logic [rtce_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/rtce_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtce_cfg_regs
// Mode registers of the converter, written over the configuration channel.
// ----------------------------------------------------------------------------
module rtce_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  rtce_cfg_if.sink           cfg,
  output rtce_pkg::rtce_cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.data_is_binary <= 1'b0;
      regs.hours_24       <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rtce_pkg::REG_DATA_IS_BINARY: regs.data_is_binary <= cfg.data[0];
        rtce_pkg::REG_HOURS_24:       regs.hours_24       <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/rtc_fields_to_epoch_seconds_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_fields_to_epoch_seconds_core
// Converts one set of PC RTC register bytes into seconds since 1970.
// ----------------------------------------------------------------------------
//  port     dir   beat contents
//  fields   in    seven raw RTC bytes (seconds .. century)
//  result   out   epoch_seconds, 40 bit
//  cfg      in    register index and data bit (binary mode, 24-hour mode)
//
// one beat per cycle sustained while result.ready is high; a beat passes through
// the seven register stages: decode, year/hour, divides,
// leap and year days, day sum, day multiply, final add
// each stage moves when it is empty or the one after it moves, so bubbles close
// reset empties the pipeline and restores binary = 0, 24-hour = 1
// ----------------------------------------------------------------------------
module rtc_fields_to_epoch_seconds_core (
  input  wire logic  clk,
  input  wire logic  rst,
  rtce_fields_if.sink  fields,
  rtce_result_if.source result,
  rtce_cfg_if.sink   cfg
);

  localparam int unsigned N = rtce_pkg::STAGES;

  rtce_pkg::rtce_cfg_t regs;

  rtce_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // ---- stage control
  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !vld[N-1] || result.ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign fields.ready = en[0];
  assign result.valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= fields.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---- stage 1: field decode
  logic [7:0] s1_sec, s1_min, s1_hour, s1_day, s1_month, s1_ylow, s1_cent;
  logic       s1_pm;
  logic [7:0] hour_src;

  assign hour_src = regs.hours_24 ? fields.raw_hours : {1'b0, fields.raw_hours[6:0]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sec   <= rtce_pkg::decode(fields.raw_seconds, regs.data_is_binary);
      s1_min   <= rtce_pkg::decode(fields.raw_minutes, regs.data_is_binary);
      s1_hour  <= rtce_pkg::decode(hour_src, regs.data_is_binary);
      s1_day   <= rtce_pkg::decode(fields.raw_day, regs.data_is_binary);
      s1_month <= rtce_pkg::decode(fields.raw_month, regs.data_is_binary);
      s1_ylow  <= rtce_pkg::decode(fields.raw_year_low, regs.data_is_binary);
      s1_cent  <= rtce_pkg::decode(fields.raw_century, regs.data_is_binary);
      s1_pm    <= !regs.hours_24 && fields.raw_hours[7];
    end
  end

  // ---- stage 2: year, pm hour, month table, day offset
  // pm hour is at most 127 + 12, so a few parallel compares do the mod 24
  function automatic logic [7:0] mod24(input logic [7:0] x);
    logic [7:0] r;
    priority if (x >= 8'd120) r = x - 8'd120;
    else if (x >= 8'd96)      r = x - 8'd96;
    else if (x >= 8'd72)      r = x - 8'd72;
    else if (x >= 8'd48)      r = x - 8'd48;
    else if (x >= 8'd24)      r = x - 8'd24;
    else                      r = x;
    return r;
  endfunction

  logic [rtce_pkg::YEAR_W-1:0]  s2_year;
  logic [7:0]                   s2_hour, s2_min, s2_sec, s2_dayoff;
  logic [rtce_pkg::MDAYS_W-1:0] s2_mdays;
  logic                         s2_mfeb;
  logic [7:0]                   months_raw;
  logic [3:0]                   months;

  always_comb begin
    months_raw = (s1_month == 8'd0) ? 8'd0 : s1_month - 8'd1;
    months     = (months_raw > 8'd12) ? 4'd12 : months_raw[3:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_year   <= rtce_pkg::YEAR_W'(s1_cent) * rtce_pkg::YEAR_W'(100)
                 + rtce_pkg::YEAR_W'(s1_ylow);
      s2_hour   <= s1_pm ? mod24(s1_hour + 8'(rtce_pkg::PM_HOURS)) : s1_hour;
      s2_min    <= s1_min;
      s2_sec    <= s1_sec;
      s2_dayoff <= (s1_day == 8'd0) ? 8'd0 : s1_day - 8'd1;
      s2_mdays  <= rtce_pkg::days_before(months);
      s2_mfeb   <= (months >= 4'd2);
    end
  end

  // ---- stage 3: divides by 100 and 400, time of day
  logic [rtce_pkg::YEAR_W-1:0]  ym1_2;
  logic [rtce_pkg::PROD_W-1:0]  prod_y, prod_m, prod_q;
  logic [rtce_pkg::YEAR_W-1:0]  s3_year;
  logic [8:0]                   s3_q100y, s3_q100m;
  logic [6:0]                   s3_q400m;
  logic [rtce_pkg::HMS_W-1:0]   s3_hms;
  logic [rtce_pkg::MDAYS_W-1:0] s3_mdays;
  logic                         s3_mfeb;
  logic [7:0]                   s3_dayoff;

  always_comb begin
    ym1_2  = s2_year - 15'd1;
    prod_y = rtce_pkg::PROD_W'(s2_year) * rtce_pkg::PROD_W'(rtce_pkg::DIV100_MUL);
    prod_m = rtce_pkg::PROD_W'(ym1_2) * rtce_pkg::PROD_W'(rtce_pkg::DIV100_MUL);
    prod_q = rtce_pkg::PROD_W'(ym1_2[14:2]) * rtce_pkg::PROD_W'(rtce_pkg::DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_year   <= s2_year;
      s3_q100y  <= prod_y[29:21];
      s3_q100m  <= prod_m[29:21];
      s3_q400m  <= prod_q[27:21];
      s3_hms    <= rtce_pkg::HMS_W'(s2_hour) * rtce_pkg::HMS_W'(rtce_pkg::SECS_PER_HOUR)
                 + rtce_pkg::HMS_W'(s2_min) * rtce_pkg::HMS_W'(rtce_pkg::SECS_PER_MIN)
                 + rtce_pkg::HMS_W'(s2_sec);
      s3_mdays  <= s2_mdays;
      s3_mfeb   <= s2_mfeb;
      s3_dayoff <= s2_dayoff;
    end
  end

  // ---- stage 4: leap test, whole-year days, days within the year
  logic [rtce_pkg::YEAR_W-1:0]  r100_full, ym1_4, yspan;
  logic [13:0]                  leaps;
  logic                         leap;
  logic [rtce_pkg::DAYS_W-1:0]  s4_ydays;
  logic [rtce_pkg::MPART_W-1:0] s4_mpart;
  logic [rtce_pkg::HMS_W-1:0]   s4_hms;

  always_comb begin
    r100_full = s3_year - rtce_pkg::YEAR_W'(s3_q100y) * rtce_pkg::YEAR_W'(100);
    leap      = ((s3_year[1:0] == 2'd0) && (r100_full != '0))
             || ((r100_full == '0) && (s3_q100y[1:0] == 2'd0));
    ym1_4     = s3_year - 15'd1;
    leaps     = 14'(ym1_4[14:2]) - 14'(s3_q100m) + 14'(s3_q400m)
              - rtce_pkg::LEAPS_BEFORE_EPOCH;
    yspan     = s3_year - rtce_pkg::EPOCH_YEAR;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_ydays <= (s3_year > rtce_pkg::EPOCH_YEAR)
                ? rtce_pkg::DAYS_W'(yspan) * rtce_pkg::DAYS_W'(rtce_pkg::DAYS_PER_YEAR)
                  + rtce_pkg::DAYS_W'(leaps)
                : '0;
      s4_mpart <= rtce_pkg::MPART_W'(s3_mdays) + rtce_pkg::MPART_W'(leap && s3_mfeb)
                + rtce_pkg::MPART_W'(s3_dayoff);
      s4_hms   <= s3_hms;
    end
  end

  // ---- stage 5: total days
  logic [rtce_pkg::DAYS_W-1:0] s5_days;
  logic [rtce_pkg::HMS_W-1:0]  s5_hms;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_days <= s4_ydays + rtce_pkg::DAYS_W'(s4_mpart);
      s5_hms  <= s4_hms;
    end
  end

  // ---- stage 6: days to seconds
  logic [rtce_pkg::EPOCH_W-1:0] s6_dsec;
  logic [rtce_pkg::HMS_W-1:0]   s6_hms;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_dsec <= rtce_pkg::EPOCH_W'(s5_days) * rtce_pkg::EPOCH_W'(rtce_pkg::SECS_PER_DAY);
      s6_hms  <= s5_hms;
    end
  end

  // ---- stage 7: output register
  logic [rtce_pkg::EPOCH_W-1:0] s7_total;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_total <= s6_dsec + rtce_pkg::EPOCH_W'(s6_hms);
    end
  end

  assign result.epoch_seconds = s7_total;

  // ---- checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    fields.valid && fields.ready |=> vld[0])
    else $error("accepted beat did not enter the first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !result.ready |-> !fields.ready)
    else $error("input ready while every stage holds a stalled beat");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    vld[N-1] && result.ready && !vld[N-2] |=> !vld[N-1])
    else $error("taken result was repeated");

  a_div100: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> r100_full < 15'd100)
    else $error("year divide by 100 off by one");

  a_div400: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> 9'(s3_q400m) <= s3_q100m)
    else $error("quotient by 400 above quotient by 100");

endmodule
`default_nettype wire

@@ dv/rtce_epoch_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtce_epoch_checker
// Watches the field, result and configuration channels of the RTC to epoch
// core, works out the epoch seconds of every accepted field beat with its own
// copy of the mode bits and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------
module rtce_epoch_checker (
  input  logic          clk,
  input  logic          rst,
  rtce_fields_if        fields,
  rtce_result_if        result,
  rtce_cfg_if           cfg,
  output int            mismatches,
  output int            pending
);

  localparam int unsigned FIRST_YEAR = 1970;
  localparam int unsigned DAY_SECS   = 86400;
  localparam int unsigned HOUR_SECS  = 3600;
  localparam int unsigned MONTH_START [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                              304, 334, 365};

  logic                          bin_mode;
  logic                          mode_24h;
  logic [rtce_pkg::EPOCH_W-1:0]  epoch_due [$];
  logic [rtce_pkg::EPOCH_W-1:0]  want;

  function automatic int unsigned byte_value(input logic [7:0] v, input logic bin);
    if (bin) begin
      return int'(v);
    end
    return int'(v[3:0]) + int'(v[7:4]) * 10;
  endfunction

  // leap years among years 1 .. y
  function automatic int unsigned leaps_through(input int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [rtce_pkg::EPOCH_W-1:0] fields_to_epoch(
    input logic [7:0] s8, mi8, h8, d8, mo8, yl8, c8,
    input logic       bin, h24
  );
    int unsigned     secs, mins, hrs, mday, mon, year, whole_months;
    longint unsigned days, total;
    secs = byte_value(s8, bin);
    mins = byte_value(mi8, bin);
    mday = byte_value(d8, bin);
    mon  = byte_value(mo8, bin);
    year = byte_value(c8, bin) * 100 + byte_value(yl8, bin);
    if (h24) begin
      hrs = byte_value(h8, bin);
    end else begin
      // pm flag comes off before decoding, 12 pm wraps to 0
      hrs = byte_value({1'b0, h8[6:0]}, bin);
      if (h8[7]) begin
        hrs = (hrs + 12) % 24;
      end
    end
    days = 0;
    if (year > FIRST_YEAR) begin
      days = longint'(year - FIRST_YEAR) * 365
           + longint'(leaps_through(year - 1)) - longint'(leaps_through(FIRST_YEAR - 1));
    end
    whole_months = (mon == 0) ? 0 : mon - 1;
    if (whole_months > 12) begin
      whole_months = 12;
    end
    days += MONTH_START[whole_months];
    if (whole_months >= 2 && is_leap(year)) begin
      days += 1;
    end
    if (mday > 0) begin
      days += mday - 1;
    end
    total = days * DAY_SECS + longint'(hrs) * HOUR_SECS + longint'(mins) * 60
          + longint'(secs);
    return total[rtce_pkg::EPOCH_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      bin_mode   <= 1'b0;
      mode_24h   <= 1'b1;
      mismatches <= 0;
      pending    <= 0;
      epoch_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          rtce_pkg::REG_DATA_IS_BINARY: bin_mode <= cfg.data[0];
          rtce_pkg::REG_HOURS_24:       mode_24h <= cfg.data[0];
          default: ;
        endcase
      end
      // result first so a beat never matches an expectation pushed this edge
      if (result.valid && result.ready) begin
        if (epoch_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %0d", $time,
                   result.epoch_seconds);
          mismatches <= mismatches + 1;
        end else begin
          want = epoch_due.pop_front();
          if (result.epoch_seconds !== want) begin
            $display("%0t: epoch_seconds mismatch, expected %0d got %0d", $time, want,
                     result.epoch_seconds);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (fields.valid && fields.ready) begin
        epoch_due.push_back(fields_to_epoch(fields.raw_seconds, fields.raw_minutes,
                                            fields.raw_hours, fields.raw_day,
                                            fields.raw_month, fields.raw_year_low,
                                            fields.raw_century, bin_mode, mode_24h));
      end
      pending <= epoch_due.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives RTC register byte sets into the epoch seconds core under all four
// mode settings: a directed set of calendar corner cases, then well-formed
// dates mixed with raw random bytes, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [7:0] century;
    logic [7:0] yr_of_cent;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } rtc_bytes_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_gap_pct = 0;
  int   ready_stall_pct = 0;
  int   mismatches;
  int   pending;
  logic mode_bin;
  logic mode_h24;

  rtce_fields_if fields_ch ();
  rtce_result_if result_ch ();
  rtce_cfg_if    cfg_ch ();

  rtc_fields_to_epoch_seconds_core dut (
    .clk    (clk),
    .rst    (rst),
    .fields (fields_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rtce_epoch_checker epoch_check (
    .clk        (clk),
    .rst        (rst),
    .fields     (fields_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  function automatic rtc_bytes_t date_bytes(input logic [7:0] c, yl, mo, d, h, mi, s);
    rtc_bytes_t b;
    b = '{century: c, yr_of_cent: yl, month: mo, day: d, hours: h, minutes: mi, seconds: s};
    return b;
  endfunction

  function automatic logic [7:0] encode_byte(input int unsigned v, input logic bin);
    logic [3:0] tens, ones;
    if (bin) begin
      return v[7:0];
    end
    tens = 4'(v / 10);
    ones = 4'(v % 10);
    return {tens, ones};
  endfunction

  function automatic rtc_bytes_t random_fields(input logic bin, input logic h24);
    rtc_bytes_t  b;
    logic [63:0] r;
    int unsigned hr, h12;
    if ($urandom_range(99) < 25) begin
      r = {$urandom(), $urandom()};
      b = r[55:0];
      return b;
    end
    hr = $urandom_range(23);
    b.century    = encode_byte($urandom_range(22, 18), bin);
    b.yr_of_cent = encode_byte($urandom_range(99), bin);
    b.month      = encode_byte($urandom_range(12, 1), bin);
    b.day        = encode_byte($urandom_range(31, 1), bin);
    b.minutes    = encode_byte($urandom_range(59), bin);
    b.seconds    = encode_byte($urandom_range(59), bin);
    if (h24) begin
      b.hours = encode_byte(hr, bin);
    end else begin
      h12 = (hr % 12 == 0) ? 12 : hr % 12;
      b.hours = encode_byte(h12, bin) | ((hr >= 12) ? 8'h80 : 8'h00);
    end
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_fields(input rtc_bytes_t b);
    while ($urandom_range(99) < send_gap_pct) begin
      fields_ch.valid <= 1'b0;
      @(negedge clk);
    end
    fields_ch.valid        <= 1'b1;
    fields_ch.raw_seconds  <= b.seconds;
    fields_ch.raw_minutes  <= b.minutes;
    fields_ch.raw_hours    <= b.hours;
    fields_ch.raw_day      <= b.day;
    fields_ch.raw_month    <= b.month;
    fields_ch.raw_year_low <= b.yr_of_cent;
    fields_ch.raw_century  <= b.century;
    @(posedge clk);
    while (!fields_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    fields_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [rtce_pkg::CFG_IDX_W-1:0] idx, input logic val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic set_mode(input logic bin, input logic h24);
    wait_drained();
    write_reg(rtce_pkg::REG_DATA_IS_BINARY, bin);
    write_reg(rtce_pkg::REG_HOURS_24, h24);
    cfg_ch.valid <= 1'b0;
    mode_bin = bin;
    mode_h24 = h24;
  endtask

  initial begin
    int combo;
    fields_ch.valid        = 1'b0;
    fields_ch.raw_seconds  = '0;
    fields_ch.raw_minutes  = '0;
    fields_ch.raw_hours    = '0;
    fields_ch.raw_day      = '0;
    fields_ch.raw_month    = '0;
    fields_ch.raw_year_low = '0;
    fields_ch.raw_century  = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;
    result_ch.ready        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // bcd, 24-hour
    set_mode(1'b0, 1'b1);
    send_fields(date_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_fields(date_bytes(8'h19, 8'h70, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
    send_fields(date_bytes(8'h19, 8'h69, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
    send_fields(date_bytes(8'h20, 8'h00, 8'h02, 8'h29, 8'h12, 8'h34, 8'h56));
    send_fields(date_bytes(8'h20, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h01));
    send_fields(date_bytes(8'h21, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
    send_fields(date_bytes(8'h20, 8'h24, 8'h00, 8'h00, 8'h05, 8'h06, 8'h07));
    send_fields(date_bytes(8'h20, 8'h23, 8'h13, 8'h15, 8'h10, 8'h20, 8'h30));
    send_fields(date_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_fields(date_bytes(8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99));
    send_fields(date_bytes(8'h2A, 8'h5F, 8'h0C, 8'hAF, 8'h3B, 8'hF0, 8'h7E));
    // bcd, 12-hour
    set_mode(1'b0, 1'b0);
    send_fields(date_bytes(8'h20, 8'h10, 8'h06, 8'h15, 8'h12, 8'h00, 8'h00));
    send_fields(date_bytes(8'h20, 8'h10, 8'h06, 8'h15, 8'h92, 8'h00, 8'h00));
    send_fields(date_bytes(8'h20, 8'h10, 8'h06, 8'h15, 8'h81, 8'h30, 8'h00));
    send_fields(date_bytes(8'h20, 8'h10, 8'h06, 8'h15, 8'h80, 8'h00, 8'h00));
    send_fields(date_bytes(8'h20, 8'h10, 8'h06, 8'h15, 8'hFF, 8'h59, 8'h59));
    // binary, 24-hour
    set_mode(1'b1, 1'b1);
    send_fields(date_bytes(8'd19, 8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0));
    send_fields(date_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_fields(date_bytes(8'd20, 8'd0, 8'd2, 8'd29, 8'd23, 8'd59, 8'd59));
    send_fields(date_bytes(8'd21, 8'd0, 8'd12, 8'd31, 8'd200, 8'd0, 8'd0));
    // binary, 12-hour
    set_mode(1'b1, 1'b0);
    send_fields(date_bytes(8'd20, 8'd5, 8'd7, 8'd4, 8'h8C, 8'd0, 8'd0));
    send_fields(date_bytes(8'd20, 8'd5, 8'd7, 8'd4, 8'h0C, 8'd0, 8'd0));
    send_fields(date_bytes(8'd20, 8'd5, 8'd7, 8'd4, 8'h8B, 8'd1, 8'd2));
    send_fields(date_bytes(8'd20, 8'd5, 8'd7, 8'd4, 8'hFF, 8'd3, 8'd4));

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_gap_pct    = 13;
          ready_stall_pct = 66;
        end
        1: begin
          send_gap_pct    = 66;
          ready_stall_pct = 13;
        end
        default: begin
          send_gap_pct    = 0;
          ready_stall_pct = 0;
        end
      endcase
      for (int k = 0; k < 2; k++) begin
        combo = 2 * p + k;
        set_mode(combo[1], !combo[0]);
        for (int i = 0; i < 100; i++) begin
          // hold the sender off until the pipeline has fully drained
          if (p == 0 && k == 0 && i == 50) begin
            wait_drained();
          end
          send_fields(random_fields(mode_bin, mode_h24));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("rtc_fields_to_epoch_seconds_core verification clean");
    end else begin
      $display("rtc_fields_to_epoch_seconds_core verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rtc_fields_to_epoch_seconds_core verification failed");
    $finish;
  end

endmodule
